// ----- src/tile_disk_member_counter_macros.svh -----
`ifndef TILE_DISK_MEMBER_COUNTER_MACROS_SVH
`define TILE_DISK_MEMBER_COUNTER_MACROS_SVH

// same-cycle implication
`define TDMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdmc assertion failed");

// next-cycle implication
`define TDMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdmc assertion failed");

`endif

// ----- src/tdmc_pkg.sv -----
package tdmc_pkg;

	localparam int MAP_SIZE_DEF    = 256;
	localparam int COUNT_WIDTH_DEF = 8;
	localparam int FRAC_BITS_DEF   = 4;

	localparam int TILE_W = 8;
	localparam int FIX_W  = 12;
	localparam int OUT_W  = 17;
	localparam int SQ_W   = 2 * FIX_W;
	localparam int ROOT_W = FIX_W;
	localparam int S_W    = 16;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REMOVE,
		OP_QUERY
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [TILE_W-1:0] tile_x;
		logic [TILE_W-1:0] tile_y;
		logic [FIX_W-1:0]  center_x;
		logic [FIX_W-1:0]  center_y;
		logic [FIX_W-1:0]  radius;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_ROW,
		ST_SQRT,
		ST_SPAN,
		ST_COLS,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ----- src/tdmc_ram.sv -----
module tdmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/tdmc_sqrt.sv -----
module tdmc_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tdmc_pkg::SQ_W-1:0]   value,
	output logic                        done,
	output logic [tdmc_pkg::ROOT_W-1:0] root
);
	import tdmc_pkg::*;

	localparam int ITER  = SQ_W / 2;
	localparam int CNT_W = $clog2(ITER + 1);

	logic [SQ_W-1:0]  v_q, res_q, bit_q, trial;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ----- src/tdmc_front.sv -----
module tdmc_front #(
	parameter int MAP_SIZE = tdmc_pkg::MAP_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [1:0]                  func,
	input  logic [tdmc_pkg::TILE_W-1:0] tile_x,
	input  logic [tdmc_pkg::TILE_W-1:0] tile_y,
	input  logic [tdmc_pkg::FIX_W-1:0]  center_x,
	input  logic [tdmc_pkg::FIX_W-1:0]  center_y,
	input  logic [tdmc_pkg::FIX_W-1:0]  radius,
	input  logic                        hold,
	output logic                        full,
	output logic                        cmd_valid,
	input  logic                        cmd_take,
	output tdmc_pkg::cmd_t              cmd
);
	import tdmc_pkg::*;

	cmd_t       fifo_q [2];
	cmd_t       new_cmd;
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept, in_map, keep, enq, deq;

	assign full      = (cnt_q == 2'd2) || hold;
	assign accept    = push && !full;
	assign in_map    = (32'(tile_x) < 32'(MAP_SIZE)) && (32'(tile_y) < 32'(MAP_SIZE));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign deq       = cmd_take && cmd_valid;
	assign enq       = accept && keep;

	always_comb begin
		new_cmd.tile_x   = tile_x;
		new_cmd.tile_y   = tile_y;
		new_cmd.center_x = center_x;
		new_cmd.center_y = center_y;
		new_cmd.radius   = radius;
		case (func)
			FUNC_ADD: begin
				new_cmd.op = OP_ADD;
				keep       = in_map;
			end
			FUNC_REMOVE: begin
				new_cmd.op = OP_REMOVE;
				keep       = in_map;
			end
			FUNC_QUERY: begin
				new_cmd.op = OP_QUERY;
				keep       = 1'b1;
			end
			default: begin
				new_cmd.op = OP_QUERY;
				keep       = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end
endmodule

// ----- src/tdmc_back.sv -----
module tdmc_back #(
	parameter int MAP_SIZE    = tdmc_pkg::MAP_SIZE_DEF,
	parameter int COUNT_WIDTH = tdmc_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = tdmc_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  tdmc_pkg::cmd_t             cmd,
	output logic                       cmd_take,
	output logic                       clearing,
	output logic                       empty,
	input  logic                       pop,
	output logic [tdmc_pkg::OUT_W-1:0] member_count,
	output logic [tdmc_pkg::OUT_W-1:0] nonmember_count
);
	import tdmc_pkg::*;

	localparam int IDX_W  = $clog2(MAP_SIZE);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int K_W    = FIX_W + 1;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
	localparam logic signed [S_W-1:0]  MAP_LAST = S_W'(MAP_SIZE - 1);
	localparam logic signed [S_W-1:0]  MAP_LIM  = S_W'(MAP_SIZE);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]      clr_q, addr_q, raddr, waddr;
	logic                   we;
	logic [COUNT_WIDTH-1:0] wdata, rdata;
	cmd_t                   cur_q;
	logic [SQ_W-1:0]        rsq_q, sq;
	logic [K_W-1:0]         steps_q, k_q;
	logic [IDX_W-1:0]       iy_q, x_q, maxx_q;
	logic [OUT_W-1:0]       mem_acc_q, non_acc_q, member_q, non_q;
	logic                   rd_vld_s1, res_full_q;
	logic                   sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]      root;

	logic [IDX_W+TILE_W-1:0] tx_ext, ty_ext;
	logic [ADDR_W-1:0]       tile_addr;

	logic signed [S_W-1:0]   cx_s, cy_s, r_s, kf, yf, dyf, negabs, iy_full;
	logic signed [2*S_W-1:0] dyf_sq;
	logic signed [S_W-1:0]   dx, x1, x2, minx_full, maxx_full, maxx_cl;
	logic                    row_skip, span_empty, last_row, adv_k, res_load;

	assign tx_ext    = {{IDX_W{1'b0}}, cmd.tile_x};
	assign ty_ext    = {{IDX_W{1'b0}}, cmd.tile_y};
	assign tile_addr = {ty_ext[IDX_W-1:0], tx_ext[IDX_W-1:0]};

	assign cx_s   = S_W'(cur_q.center_x);
	assign cy_s   = S_W'(cur_q.center_y);
	assign r_s    = S_W'(cur_q.radius);
	assign kf     = S_W'(k_q) << FRAC_BITS;
	assign yf     = cy_s - r_s + kf;
	assign dyf    = kf - r_s;
	assign dyf_sq = dyf * dyf;
	assign sq     = rsq_q - dyf_sq[SQ_W-1:0];
	assign negabs = -yf;
	assign iy_full = yf >>> FRAC_BITS;

	always_comb begin
		if (yf < 0) begin
			row_skip = ((negabs >>> FRAC_BITS) != 0);
		end else begin
			row_skip = (iy_full >= MAP_LIM);
		end
	end

	assign dx        = S_W'(root);
	assign x1        = cx_s - dx;
	assign x2        = cx_s + dx;
	assign minx_full = (x1 <= 0) ? '0 : (x1 >>> FRAC_BITS);
	assign maxx_full = x2 >>> FRAC_BITS;
	assign maxx_cl   = (maxx_full > MAP_LAST) ? MAP_LAST : maxx_full;
	assign span_empty = (minx_full > maxx_cl);
	assign last_row   = (k_q == steps_q);

	tdmc_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sqrt_start),
		.value (sq),
		.done  (sqrt_done),
		.root  (root)
	);

	tdmc_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_ADD, OP_REMOVE: state_d = ST_UPD_RD;
						OP_QUERY:          state_d = ST_ROW;
						default:           state_d = ST_IDLE;
					endcase
				end
			end
			ST_UPD_RD: state_d = ST_UPD_WR;
			ST_UPD_WR: state_d = ST_IDLE;
			ST_ROW: begin
				if (!row_skip) state_d = ST_SQRT;
				else if (last_row) state_d = ST_DONE;
			end
			ST_SQRT: begin
				if (sqrt_done) state_d = ST_SPAN;
			end
			ST_SPAN: begin
				if (!span_empty) state_d = ST_COLS;
				else if (last_row) state_d = ST_DONE;
				else state_d = ST_ROW;
			end
			ST_COLS: begin
				if (x_q == maxx_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = last_row ? ST_DONE : ST_ROW;
			ST_DONE: begin
				if (!res_full_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_take   = 1'b0;
		we         = 1'b0;
		waddr      = addr_q;
		wdata      = rdata;
		raddr      = addr_q;
		sqrt_start = 1'b0;
		adv_k      = 1'b0;
		res_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_IDLE: cmd_take = cmd_valid;
			ST_UPD_WR: begin
				we = 1'b1;
				if (cur_q.op == OP_ADD) begin
					wdata = (rdata == CNT_MAX) ? rdata : rdata + 1'b1;
				end else begin
					wdata = (rdata == '0) ? rdata : rdata - 1'b1;
				end
			end
			ST_ROW: begin
				sqrt_start = !row_skip;
				adv_k      = row_skip && !last_row;
			end
			ST_SPAN:  adv_k = span_empty && !last_row;
			ST_COLS:  raddr = {iy_q, x_q};
			ST_DRAIN: adv_k = !last_row;
			ST_DONE:  res_load = !res_full_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_COLS);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				res_full_q <= 1'b1;
			end else if (pop && res_full_q) begin
				res_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q   <= cmd;
			addr_q  <= tile_addr;
			rsq_q   <= SQ_W'(cmd.radius) * SQ_W'(cmd.radius);
			steps_q <= K_W'((K_W'(cmd.radius) << 1) >> FRAC_BITS);
			k_q     <= '0;
		end else if (adv_k) begin
			k_q <= k_q + 1'b1;
		end
		if (state_q == ST_ROW && !row_skip) begin
			iy_q <= (yf < 0) ? '0 : iy_full[IDX_W-1:0];
		end
		if (state_q == ST_SPAN) begin
			x_q    <= minx_full[IDX_W-1:0];
			maxx_q <= maxx_cl[IDX_W-1:0];
		end else if (state_q == ST_COLS) begin
			x_q <= x_q + 1'b1;
		end
		if (cmd_take) begin
			mem_acc_q <= '0;
			non_acc_q <= '0;
		end else if (rd_vld_s1) begin
			if (rdata != '0) begin
				if (mem_acc_q != OUT_MAX) mem_acc_q <= mem_acc_q + 1'b1;
			end else begin
				if (non_acc_q != OUT_MAX) non_acc_q <= non_acc_q + 1'b1;
			end
		end
		if (res_load) begin
			member_q <= mem_acc_q;
			non_q    <= non_acc_q;
		end
	end

	assign clearing        = (state_q == ST_CLEAR);
	assign empty           = !res_full_q;
	assign member_count    = member_q;
	assign nonmember_count = non_q;
endmodule

// ----- src/tile_disk_member_counter.sv -----
// Tile reference counter with disk query. Requests enter a two-deep queue
// and are executed one at a time by a sequencer over a count memory with one
// read port and one write port. Add and remove read the tile's count and
// write it back incremented or decremented (read, modify, write). A query
// visits each disk row in turn: a row off the map is skipped; otherwise a
// bit-serial square root gives its column span, and if the span is not empty
// the row walk reads one tile per cycle from the count memory. A radius of
// 4095 walks 512 rows. The result waits in an output register until popped, and
// the sequencer holds the next query's result until then. After reset a
// clearing pass writes all 2^(2*ceil(log2 MAP_SIZE)) count words (65536 at
// MAP_SIZE 256), and full stays high until it is done.
`include "tile_disk_member_counter_macros.svh"

module tile_disk_member_counter #(
	parameter int MAP_SIZE    = tdmc_pkg::MAP_SIZE_DEF,
	parameter int COUNT_WIDTH = tdmc_pkg::COUNT_WIDTH_DEF,
	parameter int FRAC_BITS   = tdmc_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  func,
	input  logic [tdmc_pkg::TILE_W-1:0] tile_x,
	input  logic [tdmc_pkg::TILE_W-1:0] tile_y,
	input  logic [tdmc_pkg::FIX_W-1:0]  center_x,
	input  logic [tdmc_pkg::FIX_W-1:0]  center_y,
	input  logic [tdmc_pkg::FIX_W-1:0]  radius,
	output logic                        empty,
	input  logic                        pop,
	output logic [tdmc_pkg::OUT_W-1:0]  member_count,
	output logic [tdmc_pkg::OUT_W-1:0]  nonmember_count
);
	import tdmc_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_take, clearing;

	tdmc_front #(
		.MAP_SIZE(MAP_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.func     (func),
		.tile_x   (tile_x),
		.tile_y   (tile_y),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.hold     (clearing),
		.full     (full),
		.cmd_valid(cmd_valid),
		.cmd_take (cmd_take),
		.cmd      (cmd)
	);

	tdmc_back #(
		.MAP_SIZE   (MAP_SIZE),
		.COUNT_WIDTH(COUNT_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_take       (cmd_take),
		.clearing       (clearing),
		.empty          (empty),
		.pop            (pop),
		.member_count   (member_count),
		.nonmember_count(nonmember_count)
	);

	`TDMC_ASSERT_NOW(a_clear_blocks_push, clk, arst_n, clearing, full)
	`TDMC_ASSERT_NOW(a_clear_no_result, clk, arst_n, clearing, empty)
	`TDMC_ASSERT_NEXT(a_pop_frees_slot, clk, arst_n, (pop && !empty), empty)
endmodule
